@@ rtl/bgi_pkg.sv @@
// Shared types and constants for the bilinear grid interpolator.
package bgi_pkg;

  localparam int X_POINTS    = 4;
  localparam int Y_POINTS    = 16;
  localparam int GRID_N      = X_POINTS * Y_POINTS;
  localparam int XI_W        = $clog2(X_POINTS);
  localparam int YI_W        = $clog2(Y_POINTS);
  localparam int GA_W        = $clog2(GRID_N);
  localparam int DIV_STEPS   = 32;
  localparam int GRID_READS  = 4;
  localparam int CNT_W       = 6;

  localparam logic signed [15:0] VAL_MAX = 16'sh7FFF;
  localparam logic signed [15:0] VAL_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    ACT_WR_X    = 2'd0,
    ACT_WR_Y    = 2'd1,
    ACT_WR_GRID = 2'd2,
    ACT_EVAL    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    LERP_LOW  = 2'd0,
    LERP_HIGH = 2'd1,
    LERP_Y    = 2'd2
  } lerp_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MINMAX,
    ST_CLAMP,
    ST_SEARCH,
    ST_GRID,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         index_x;
    logic [3:0]         index_y;
    logic signed [15:0] write_value;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] interpolated;
    logic [1:0]         cell_x;
    logic [3:0]         cell_y;
  } out_item_t;

  typedef struct packed {
    logic  start;
    logic  mm_step;
    logic  clamp;
    logic  srch_step;
    logic  grid_step;
    logic  mul;
    logic  dinit;
    logic  div_step;
    logic  fin;
    logic  load_out;
    logic  cnt_clr;
    logic  cnt_inc;
    lerp_e lsel;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic grid_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/bgi_ctrl.sv @@
// Sequencing controller for the bilinear grid interpolator.
module bgi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             is_eval_i,
  input  bgi_pkg::status_t st_i,
  output logic             in_ready_o,
  output bgi_pkg::cmd_t    cmd_o
);

  bgi_pkg::state_e state_q, state_d;
  bgi_pkg::lerp_e  lsel_q, lsel_d;
  logic            start;

  assign in_ready_o = (state_q == bgi_pkg::ST_IDLE);
  assign start      = in_ready_o && in_valid_i && is_eval_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgi_pkg::ST_IDLE;
      lsel_q  <= bgi_pkg::LERP_LOW;
    end else begin
      state_q <= state_d;
      lsel_q  <= lsel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    lsel_d  = lsel_q;
    unique case (state_q)
      bgi_pkg::ST_IDLE: begin
        if (start) begin
          state_d = bgi_pkg::ST_MINMAX;
          lsel_d  = bgi_pkg::LERP_LOW;
        end
      end
      bgi_pkg::ST_MINMAX: if (st_i.scan_last) state_d = bgi_pkg::ST_CLAMP;
      bgi_pkg::ST_CLAMP:  state_d = bgi_pkg::ST_SEARCH;
      bgi_pkg::ST_SEARCH: if (st_i.scan_last) state_d = bgi_pkg::ST_GRID;
      bgi_pkg::ST_GRID:   if (st_i.grid_last) state_d = bgi_pkg::ST_MUL;
      bgi_pkg::ST_MUL:    state_d = bgi_pkg::ST_DINIT;
      bgi_pkg::ST_DINIT:  state_d = bgi_pkg::ST_DIV;
      bgi_pkg::ST_DIV:    if (st_i.div_last) state_d = bgi_pkg::ST_FIN;
      bgi_pkg::ST_FIN: begin
        unique case (lsel_q)
          bgi_pkg::LERP_LOW: begin
            lsel_d  = bgi_pkg::LERP_HIGH;
            state_d = bgi_pkg::ST_MUL;
          end
          bgi_pkg::LERP_HIGH: begin
            lsel_d  = bgi_pkg::LERP_Y;
            state_d = bgi_pkg::ST_MUL;
          end
          default: state_d = bgi_pkg::ST_OUT;
        endcase
      end
      bgi_pkg::ST_OUT:    if (st_i.out_free) state_d = bgi_pkg::ST_IDLE;
      default:            state_d = bgi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.lsel      = lsel_q;
    cmd_o.start     = start;
    unique case (state_q)
      bgi_pkg::ST_IDLE:   cmd_o.cnt_clr = start;
      bgi_pkg::ST_MINMAX: begin
        cmd_o.mm_step = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      bgi_pkg::ST_CLAMP: begin
        cmd_o.clamp   = 1'b1;
        cmd_o.cnt_clr = 1'b1;
      end
      bgi_pkg::ST_SEARCH: begin
        cmd_o.srch_step = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        cmd_o.cnt_clr   = st_i.scan_last;
      end
      bgi_pkg::ST_GRID: begin
        cmd_o.grid_step = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
      end
      bgi_pkg::ST_MUL:    cmd_o.mul = 1'b1;
      bgi_pkg::ST_DINIT: begin
        cmd_o.dinit   = 1'b1;
        cmd_o.cnt_clr = 1'b1;
      end
      bgi_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
      end
      bgi_pkg::ST_FIN:    cmd_o.fin = 1'b1;
      bgi_pkg::ST_OUT:    cmd_o.load_out = st_i.out_free;
      default:            cmd_o.cnt_clr = 1'b0;
    endcase
  end

  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> state_q == bgi_pkg::ST_MINMAX)
    else $error("evaluate item did not start the axis scan");

  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgi_pkg::ST_DIV && st_i.div_last) |=> state_q == bgi_pkg::ST_FIN)
    else $error("divider finish not followed by result step");

  a_lsel_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bgi_pkg::ST_FIN && state_q != bgi_pkg::ST_IDLE) |=> $stable(lsel_q))
    else $error("interpolation select changed outside result step");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgi_pkg::ST_OUT && !st_i.out_free) |=> state_q == bgi_pkg::ST_OUT)
    else $error("result dropped while output register busy");

endmodule

@@ rtl/bgi_dp.sv @@
// Datapath: axis and grid storage, scan, cell search, multiply and serial divide.
module bgi_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  bgi_pkg::in_item_t   in_item_i,
  input  bgi_pkg::cmd_t       cmd_i,
  output bgi_pkg::status_t    st_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output bgi_pkg::out_item_t  out_item_o
);

  logic signed [15:0] x_q [bgi_pkg::X_POINTS];
  logic signed [15:0] y_q [bgi_pkg::Y_POINTS];
  logic signed [15:0] grid_q [bgi_pkg::GRID_N];
  logic signed [15:0] rd_q;
  logic [bgi_pkg::GA_W-1:0] waddr, raddr;

  logic [bgi_pkg::CNT_W-1:0] cnt_q;
  logic signed [15:0] sx_q, sy_q, xmin_q, xmax_q, ymin_q, ymax_q;
  logic signed [15:0] x0_q, x1_q, y0_q, y1_q, xprev_q, yprev_q;
  logic signed [15:0] g_q [bgi_pkg::GRID_READS];
  logic signed [15:0] r_q, t_q, res_q, b0_q;
  logic [bgi_pkg::XI_W-1:0] cx_q;
  logic [bgi_pkg::YI_W-1:0] cy_q;
  logic xfound_q, yfound_q;
  logic signed [16:0] den_q;
  logic signed [33:0] num_q;
  logic dneg_q;
  logic [15:0] dmag_q, rem_q;
  logic [31:0] quo_q;
  logic out_valid_q;
  bgi_pkg::out_item_t out_q;

  logic signed [15:0] x_rd, y_rd, cx_t, cy_t;
  logic x_in;
  logic signed [15:0] p, a0, a1, b0, b1;
  logic signed [16:0] dp_s, db_s;
  logic signed [33:0] nmag, qs, sum;
  logic signed [16:0] dmag;
  logic [16:0] trial;
  logic signed [15:0] sat, res;
  logic [1:0] gk;
  logic [bgi_pkg::XI_W-1:0] gx;
  logic [bgi_pkg::YI_W-1:0] gy;
  logic [bgi_pkg::CNT_W-1:0] cnt_m1;

  assign x_in   = cnt_q < bgi_pkg::CNT_W'(bgi_pkg::X_POINTS);
  assign x_rd   = x_q[cnt_q[bgi_pkg::XI_W-1:0]];
  assign y_rd   = y_q[cnt_q[bgi_pkg::YI_W-1:0]];
  assign cnt_m1 = cnt_q - bgi_pkg::CNT_W'(1);

  assign cx_t = (sx_q < xmin_q) ? xmin_q : sx_q;
  assign cy_t = (sy_q < ymin_q) ? ymin_q : sy_q;

  assign waddr = bgi_pkg::GA_W'(int'(in_item_i.index_x) * bgi_pkg::Y_POINTS
                                + int'(in_item_i.index_y));
  assign gk    = cnt_q[1:0];
  assign gx    = cx_q + bgi_pkg::XI_W'(gk[0]);
  assign gy    = cy_q + bgi_pkg::YI_W'(gk[1]);
  assign raddr = bgi_pkg::GA_W'(int'(gx) * bgi_pkg::Y_POINTS + int'(gy));

  always_comb begin
    unique case (cmd_i.lsel)
      bgi_pkg::LERP_LOW: begin
        p = sx_q; a0 = x0_q; a1 = x1_q; b0 = g_q[0]; b1 = g_q[1];
      end
      bgi_pkg::LERP_HIGH: begin
        p = sx_q; a0 = x0_q; a1 = x1_q; b0 = g_q[2]; b1 = g_q[3];
      end
      default: begin
        p = sy_q; a0 = y0_q; a1 = y1_q; b0 = r_q; b1 = t_q;
      end
    endcase
  end

  assign dp_s  = 17'(p) - 17'(a0);
  assign db_s  = 17'(b1) - 17'(b0);
  assign nmag  = num_q[33] ? -num_q : num_q;
  assign dmag  = den_q[16] ? -den_q : den_q;
  assign trial = {rem_q, quo_q[31]};
  assign qs    = dneg_q ? -{2'b00, quo_q} : {2'b00, quo_q};
  assign sum   = 34'(b0_q) + qs;
  assign sat   = (sum > 34'(bgi_pkg::VAL_MAX)) ? bgi_pkg::VAL_MAX :
                 (sum < 34'(bgi_pkg::VAL_MIN)) ? bgi_pkg::VAL_MIN : sum[15:0];
  assign res   = (den_q == '0) ? b0_q : sat;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_item_i.action == bgi_pkg::ACT_WR_X &&
        int'(in_item_i.index_x) < bgi_pkg::X_POINTS) begin
      x_q[in_item_i.index_x[bgi_pkg::XI_W-1:0]] <= in_item_i.write_value;
    end
    if (wr_en_i && in_item_i.action == bgi_pkg::ACT_WR_Y &&
        int'(in_item_i.index_y) < bgi_pkg::Y_POINTS) begin
      y_q[in_item_i.index_y[bgi_pkg::YI_W-1:0]] <= in_item_i.write_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_item_i.action == bgi_pkg::ACT_WR_GRID &&
        int'(in_item_i.index_x) < bgi_pkg::X_POINTS &&
        int'(in_item_i.index_y) < bgi_pkg::Y_POINTS) begin
      grid_q[waddr] <= in_item_i.write_value;
    end
    rd_q <= grid_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + bgi_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sx_q   <= in_item_i.sample_x;
      sy_q   <= in_item_i.sample_y;
      xmin_q <= bgi_pkg::VAL_MAX;
      xmax_q <= bgi_pkg::VAL_MIN;
      ymin_q <= bgi_pkg::VAL_MAX;
      ymax_q <= bgi_pkg::VAL_MIN;
    end
    if (cmd_i.mm_step) begin
      if (x_in && x_rd < xmin_q) xmin_q <= x_rd;
      if (x_in && x_rd > xmax_q) xmax_q <= x_rd;
      if (y_rd < ymin_q) ymin_q <= y_rd;
      if (y_rd > ymax_q) ymax_q <= y_rd;
    end
    if (cmd_i.clamp) begin
      sx_q     <= (cx_t > xmax_q) ? xmax_q : cx_t;
      sy_q     <= (cy_t > ymax_q) ? ymax_q : cy_t;
      xfound_q <= 1'b0;
      yfound_q <= 1'b0;
    end
    if (cmd_i.srch_step) begin
      if (x_in) xprev_q <= x_rd;
      yprev_q <= y_rd;
      if (cnt_q != '0 && x_in && !xfound_q &&
          (sx_q < x_rd || cnt_q == bgi_pkg::CNT_W'(bgi_pkg::X_POINTS - 1))) begin
        xfound_q <= 1'b1;
        cx_q     <= cnt_m1[bgi_pkg::XI_W-1:0];
        x0_q     <= xprev_q;
        x1_q     <= x_rd;
      end
      if (cnt_q != '0 && !yfound_q &&
          (sy_q < y_rd || cnt_q == bgi_pkg::CNT_W'(bgi_pkg::Y_POINTS - 1))) begin
        yfound_q <= 1'b1;
        cy_q     <= cnt_m1[bgi_pkg::YI_W-1:0];
        y0_q     <= yprev_q;
        y1_q     <= y_rd;
      end
    end
    if (cmd_i.grid_step && cnt_q != '0) begin
      g_q[cnt_m1[1:0]] <= rd_q;
    end
    if (cmd_i.mul) begin
      den_q <= 17'(a1) - 17'(a0);
      num_q <= 34'(dp_s) * 34'(db_s);
      b0_q  <= b0;
    end
    if (cmd_i.dinit) begin
      dneg_q <= num_q[33] ^ den_q[16];
      quo_q  <= nmag[31:0];
      dmag_q <= dmag[15:0];
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if (trial >= {1'b0, dmag_q}) begin
        rem_q <= 16'(trial - {1'b0, dmag_q});
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.fin) begin
      unique case (cmd_i.lsel)
        bgi_pkg::LERP_LOW:  r_q   <= res;
        bgi_pkg::LERP_HIGH: t_q   <= res;
        default:            res_q <= res;
      endcase
    end
    if (cmd_i.load_out) begin
      out_q.interpolated <= res_q;
      out_q.cell_x       <= 2'(cx_q);
      out_q.cell_y       <= 4'(cy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign st_o.scan_last = cnt_q == bgi_pkg::CNT_W'(bgi_pkg::Y_POINTS - 1);
  assign st_o.grid_last = cnt_q == bgi_pkg::CNT_W'(bgi_pkg::GRID_READS);
  assign st_o.div_last  = cnt_q == bgi_pkg::CNT_W'(bgi_pkg::DIV_STEPS - 1);
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/bilinear_grid_interpolator.sv @@
// Bilinear grid interpolator top level: controller plus datapath.
// Load items are accepted every cycle while idle; in_ready_o is high only in the idle state.
// An evaluate runs, in order: a min/max scan, a clamp step, a cell search, 4 grid
// reads, three interpolations on one shared 32-step divider, and an output load.
// A new item is taken only after the last result is loaded into the output register,
// and that load waits while a previous result is still held; one item is in flight
// at a time; reset clears control state, not storage.
module bilinear_grid_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bgi_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bgi_pkg::out_item_t  out_item_o
);

  bgi_pkg::cmd_t    cmd;
  bgi_pkg::status_t st;
  logic             in_acc;
  logic             is_eval;

  assign in_acc  = in_valid_i && in_ready_o;
  assign is_eval = in_item_i.action == bgi_pkg::ACT_EVAL;

  bgi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_eval_i  (is_eval),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  bgi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_acc),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
